// ===== rtl/core/rtu_pkg.sv =====
// shared types and constants for the rtu frame gap receiver
package rtu_pkg;

	localparam int unsigned BUFFER_DEPTH_DEF = 32;
	localparam int unsigned GAP_W            = 16;
	localparam logic [GAP_W-1:0] GAP_RESET   = 16'd750;
	localparam int unsigned LEN_W            = 5;
	localparam int unsigned IDX_W            = 5;
	localparam int unsigned BYTE_W           = 8;
	localparam int unsigned OP_W             = 2;

	typedef enum logic [OP_W-1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_TURN = 2'd2,
		OP_READ = 2'd3
	} rtu_op_t;

	// result fields computed by the control path, read data comes from the store
	typedef struct packed {
		logic             frame_done;
		logic [LEN_W-1:0] frame_length;
		logic             receiver_release;
		logic             timer_active;
	} rtu_result_t;

endpackage

// ===== rtl/core/rtu_gap_ctrl.sv =====
// frame count, gap timer and transmit flag with per-transaction result logic
module rtu_gap_ctrl import rtu_pkg::*; #(
	parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	localparam int unsigned WC_W = $clog2(BUFFER_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic [OP_W-1:0]  opcode,
	input  logic [GAP_W-1:0] gap_ticks,
	output logic [WC_W-1:0]  wr_addr,
	output rtu_result_t      res
);

	logic [WC_W-1:0]  write_count_q, write_count_d;
	logic [GAP_W-1:0] gap_counter_q, gap_counter_d;
	logic             gap_running_q, gap_running_d;
	logic             transmitting_q, transmitting_d;
	logic [31:0]      wc_ext;

	assign wr_addr = write_count_q;
	assign wc_ext  = 32'(write_count_q);

	always_comb begin
		write_count_d  = write_count_q;
		gap_counter_d  = gap_counter_q;
		gap_running_d  = gap_running_q;
		transmitting_d = transmitting_q;
		res            = '0;
		case (rtu_op_t'(opcode))
			OP_BYTE: begin
				if (write_count_q == WC_W'(BUFFER_DEPTH - 1)) begin
					write_count_d = '0;
				end else begin
					write_count_d = write_count_q + 1'b1;
				end
				transmitting_d = 1'b0;
				gap_counter_d  = '0;
				gap_running_d  = 1'b1;
			end
			OP_TICK: begin
				if (gap_running_q) begin
					// counter already at or past the reload ends the silence
					if (gap_counter_q >= gap_ticks) begin
						if (!transmitting_q) begin
							res.frame_done   = 1'b1;
							res.frame_length = wc_ext[LEN_W-1:0];
							write_count_d    = '0;
						end else begin
							res.receiver_release = 1'b1;
							transmitting_d       = 1'b0;
						end
						gap_running_d = 1'b0;
						gap_counter_d = '0;
					end else begin
						gap_counter_d = gap_counter_q + 1'b1;
					end
				end
			end
			OP_TURN: begin
				transmitting_d = 1'b1;
				gap_counter_d  = '0;
				gap_running_d  = 1'b1;
			end
			default: begin
			end
		endcase
		res.timer_active = gap_running_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_count_q  <= '0;
			gap_counter_q  <= '0;
			gap_running_q  <= 1'b0;
			transmitting_q <= 1'b0;
		end else if (acc) begin
			write_count_q  <= write_count_d;
			gap_counter_q  <= gap_counter_d;
			gap_running_q  <= gap_running_d;
			transmitting_q <= transmitting_d;
		end
	end

endmodule

// ===== rtl/core/rtu_store_buf.sv =====
// frame byte store and the two-entry result buffer it reads into
module rtu_store_buf import rtu_pkg::*; #(
	parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	localparam int unsigned WC_W = $clog2(BUFFER_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              acc,
	input  logic [OP_W-1:0]   opcode,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [IDX_W-1:0]  read_index,
	input  logic [WC_W-1:0]   wr_addr,
	input  rtu_result_t       res,
	output logic              out_valid,
	input  logic              out_stall,
	output rtu_result_t       out_res,
	output logic [BYTE_W-1:0] out_data
);

	logic [BYTE_W-1:0] mem [BUFFER_DEPTH];

	logic              main_vld_q, skid_vld_q;
	rtu_result_t       main_res_q, skid_res_q;
	logic [BYTE_W-1:0] main_data_q, skid_data_q;
	logic              take, load_main, load_skid, rd_en, wr_en;
	logic [31:0]       ridx_ext;
	logic [WC_W-1:0]   rd_addr;

	assign take      = main_vld_q && !out_stall;
	assign in_stall  = skid_vld_q;
	assign acc       = in_valid && !skid_vld_q;
	assign load_main = acc && (!main_vld_q || take);
	assign load_skid = acc && main_vld_q && !take;

	assign ridx_ext = 32'(read_index);
	assign rd_addr  = ridx_ext[WC_W-1:0];
	assign rd_en    = (rtu_op_t'(opcode) == OP_READ) && (ridx_ext < BUFFER_DEPTH);
	assign wr_en    = acc && (rtu_op_t'(opcode) == OP_BYTE);

	assign out_valid = main_vld_q;
	assign out_res   = main_res_q;
	assign out_data  = main_data_q;

	// store write plus registered read into whichever entry takes the transaction
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= rx_byte;
		end
		if (load_main) begin
			main_res_q  <= res;
			main_data_q <= rd_en ? mem[rd_addr] : '0;
		end else if (take && skid_vld_q) begin
			main_res_q  <= skid_res_q;
			main_data_q <= skid_data_q;
		end
		if (load_skid) begin
			skid_res_q  <= res;
			skid_data_q <= rd_en ? mem[rd_addr] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (take || !main_vld_q) begin
				main_vld_q <= skid_vld_q || acc;
			end
			if (skid_vld_q && take) begin
				skid_vld_q <= 1'b0;
			end else if (load_skid) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/rtu_frame_gap_receiver.sv =====
// rtu_frame_gap_receiver: serial frame receiver ending frames on line silence
//
// Input channel (in_valid/in_stall) carries one opcode per transaction: a
// received byte, a timer tick, the end of a transmission, or a read of the
// byte store. Every accepted transaction yields exactly one result on the
// output channel (out_valid/out_stall): frame_done with frame_length when the
// gap timer expires in receive mode, receiver_release when it expires after
// a transmission, read_data for store reads, and timer_active each time.
// Each result is registered before out_valid. One transaction is taken every
// cycle while in_stall is low; a result register plus a one-entry skid
// register let the next transaction in while a result waits, so in_stall
// only rises once both entries are held by a stalled receiver. Throughput
// is set by the single update of the frame count and gap timer per cycle.
// The user writes gap_ticks through cfg_we/cfg_wdata while idle; the block
// does not enforce this. Silence lasts gap_ticks+1 ticks. Reset clears the
// count, timer and transmit flag and loads gap_ticks with 750; the byte
// store is not cleared, and an entry must be written before it is read.
module rtu_frame_gap_receiver import rtu_pkg::*; #(
	parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [GAP_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   opcode,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [IDX_W-1:0]  read_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              frame_done,
	output logic [LEN_W-1:0]  frame_length,
	output logic              receiver_release,
	output logic [BYTE_W-1:0] read_data,
	output logic              timer_active
);

	localparam int unsigned WC_W = $clog2(BUFFER_DEPTH);

	logic [GAP_W-1:0] gap_ticks_q;
	logic             acc;
	logic [WC_W-1:0]  wr_addr;
	rtu_result_t      res, out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_ticks_q <= GAP_RESET;
		end else if (cfg_we) begin
			gap_ticks_q <= cfg_wdata;
		end
	end

	rtu_gap_ctrl #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.opcode    (opcode),
		.gap_ticks (gap_ticks_q),
		.wr_addr   (wr_addr),
		.res       (res)
	);

	rtu_store_buf #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_store_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.acc        (acc),
		.opcode     (opcode),
		.rx_byte    (rx_byte),
		.read_index (read_index),
		.wr_addr    (wr_addr),
		.res        (res),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_res    (out_res),
		.out_data   (read_data)
	);

	assign frame_done       = out_res.frame_done;
	assign frame_length     = out_res.frame_length;
	assign receiver_release = out_res.receiver_release;
	assign timer_active     = out_res.timer_active;

endmodule
